// File: rtl/i2cms_pkg.sv
// Package for the I2C master transfer sequencer: widths and code constants.
`default_nettype none
package i2cms_pkg;

  localparam int BufDepthDefault = 32;
  localparam int CntW = 6;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RX_ACK  = 3'd3;
  localparam logic [2:0] ACT_RX_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;
  localparam logic [2:0] ACT_ABORT   = 3'd6;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LEN       = 3'd1;
  localparam logic [2:0] ERR_SLA_NACK  = 3'd2;
  localparam logic [2:0] ERR_DATA_NACK = 3'd3;
  localparam logic [2:0] ERR_ARB       = 3'd4;
  localparam logic [2:0] ERR_BUS       = 3'd5;

  // Status codes with the low three bits dropped.
  localparam logic [4:0] ST_BUS_ERR   = 5'h00;
  localparam logic [4:0] ST_START     = 5'h01;
  localparam logic [4:0] ST_RSTART    = 5'h02;
  localparam logic [4:0] ST_SLAW_ACK  = 5'h03;
  localparam logic [4:0] ST_SLAW_NACK = 5'h04;
  localparam logic [4:0] ST_DATA_ACK  = 5'h05;
  localparam logic [4:0] ST_DATA_NACK = 5'h06;
  localparam logic [4:0] ST_ARB_LOST  = 5'h07;
  localparam logic [4:0] ST_SLAR_ACK  = 5'h08;
  localparam logic [4:0] ST_SLAR_NACK = 5'h09;
  localparam logic [4:0] ST_RX_ACK    = 5'h0A;
  localparam logic [4:0] ST_RX_NACK   = 5'h0B;

endpackage
`default_nettype wire

// File: rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer with its transmit buffer memory.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | opcode data_byte target_address
//           |           |                     | read_not_write transfer_length bus_status
//   out     | output    | out_valid/out_stall | bus_action tx_byte rx_valid rx_byte
//           |           |                     | busy_res done_res error_code byte_count
//
// One transaction per cycle unless out_stall holds the pipeline back.
// The first stage decodes and updates control state while the buffer read is in
// flight; the second stage merges the read data into the output register.
// Reset clears all control state; the buffer holds garbage until loaded.
// in_stall stays high while rst is asserted.
// A stalled output still lets one more input in before in_stall rises.
`default_nettype none
module i2c_master_transfer_sequencer #(
  parameter int BUF_DEPTH = i2cms_pkg::BufDepthDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                opcode,
  input  wire logic [7:0]                data_byte,
  input  wire logic [6:0]                target_address,
  input  wire logic                      read_not_write,
  input  wire logic [i2cms_pkg::CntW-1:0] transfer_length,
  input  wire logic [7:0]                bus_status,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [2:0]                     bus_action,
  output logic [7:0]                     tx_byte,
  output logic                           rx_valid,
  output logic [7:0]                     rx_byte,
  output logic                           busy_res,
  output logic                           done_res,
  output logic [2:0]                     error_code,
  output logic [i2cms_pkg::CntW-1:0]     byte_count
);

  localparam int CW = i2cms_pkg::CntW;
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [CW:0] DEPTH_C = (CW + 1)'(BUF_DEPTH);
  localparam logic [CW-1:0] IDX_MAX = {CW{1'b1}};

  typedef enum logic [1:0] {PH_READY, PH_TX, PH_RX} phase_t;

  phase_t        phase, phase_next;
  logic [CW-1:0] load_pointer, load_pointer_next;
  logic [7:0]    address_byte, address_byte_next;
  logic [CW-1:0] length_reg, length_reg_next;
  logic [CW-1:0] byte_index, byte_index_next;
  logic [2:0]    last_error, last_error_next;

  logic [7:0]    buf_mem [BUF_DEPTH];
  logic [7:0]    mem_q;

  logic          s1_valid;
  logic [2:0]    s1_action;
  logic [7:0]    s1_txb;
  logic          s1_use_mem;
  logic          s1_rxv;
  logic [7:0]    s1_rxb;
  logic          s1_busy;
  logic          s1_done;
  logic [2:0]    s1_err;
  logic [CW-1:0] s1_count;

  logic          accept, s1_move, out_free;
  logic [2:0]    a_action;
  logic [7:0]    a_txb;
  logic          a_use_mem, a_rxv, a_done, wr_en;
  logic [4:0]    st;
  logic [CW-1:0] idx_inc;
  logic          idx_in_buf;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_free;
  assign in_stall = rst || (s1_valid && !out_free);
  assign accept   = in_valid && !in_stall;

  assign st         = bus_status[7:3];
  assign idx_inc    = (byte_index == IDX_MAX) ? byte_index : byte_index + CW'(1);
  assign idx_in_buf = {1'b0, byte_index} < DEPTH_C;

  always_comb begin
    phase_next        = phase;
    load_pointer_next = load_pointer;
    address_byte_next = address_byte;
    length_reg_next   = length_reg;
    byte_index_next   = byte_index;
    last_error_next   = last_error;
    a_action  = i2cms_pkg::ACT_NONE;
    a_txb     = 8'd0;
    a_use_mem = 1'b0;
    a_rxv     = 1'b0;
    a_done    = 1'b0;
    wr_en     = 1'b0;
    priority if (opcode == i2cms_pkg::OP_LOAD) begin
      if (phase == PH_READY && {1'b0, load_pointer} < DEPTH_C) begin
        wr_en             = 1'b1;
        load_pointer_next = load_pointer + CW'(1);
      end
    end else if (opcode == i2cms_pkg::OP_START) begin
      if (phase == PH_READY) begin
        if (transfer_length == '0 || {1'b0, transfer_length} > DEPTH_C) begin
          last_error_next = i2cms_pkg::ERR_LEN;
          a_done          = 1'b1;
        end else begin
          phase_next        = read_not_write ? PH_RX : PH_TX;
          last_error_next   = i2cms_pkg::ERR_NONE;
          address_byte_next = {target_address, read_not_write};
          length_reg_next   = transfer_length;
          byte_index_next   = '0;
          load_pointer_next = '0;
          a_action          = i2cms_pkg::ACT_START;
        end
      end
    end else if (opcode == i2cms_pkg::OP_STATUS && phase != PH_READY) begin
      unique case (st)
        i2cms_pkg::ST_START, i2cms_pkg::ST_RSTART: begin
          a_txb    = address_byte;
          a_action = i2cms_pkg::ACT_SEND;
        end
        i2cms_pkg::ST_SLAW_ACK: begin
          a_use_mem       = idx_in_buf;
          byte_index_next = idx_inc;
          a_action        = i2cms_pkg::ACT_SEND;
        end
        i2cms_pkg::ST_DATA_ACK: begin
          if (byte_index < length_reg) begin
            a_use_mem       = idx_in_buf;
            byte_index_next = idx_inc;
            a_action        = i2cms_pkg::ACT_SEND;
          end else begin
            a_action = i2cms_pkg::ACT_STOP;
          end
        end
        i2cms_pkg::ST_SLAW_NACK, i2cms_pkg::ST_SLAR_NACK: begin
          last_error_next = i2cms_pkg::ERR_SLA_NACK;
          a_action        = i2cms_pkg::ACT_STOP;
        end
        i2cms_pkg::ST_DATA_NACK: begin
          last_error_next = i2cms_pkg::ERR_DATA_NACK;
          a_action        = i2cms_pkg::ACT_STOP;
        end
        i2cms_pkg::ST_SLAR_ACK: begin
          a_action = (length_reg == CW'(1)) ? i2cms_pkg::ACT_RX_NACK
                                            : i2cms_pkg::ACT_RX_ACK;
        end
        i2cms_pkg::ST_RX_ACK: begin
          a_rxv           = 1'b1;
          byte_index_next = idx_inc;
          a_action = (({1'b0, idx_inc} + (CW + 1)'(1)) < {1'b0, length_reg})
                     ? i2cms_pkg::ACT_RX_ACK : i2cms_pkg::ACT_RX_NACK;
        end
        i2cms_pkg::ST_RX_NACK: begin
          a_rxv           = 1'b1;
          byte_index_next = idx_inc;
          a_action        = i2cms_pkg::ACT_STOP;
        end
        i2cms_pkg::ST_ARB_LOST: begin
          last_error_next = i2cms_pkg::ERR_ARB;
          a_action        = i2cms_pkg::ACT_ABORT;
        end
        i2cms_pkg::ST_BUS_ERR: begin
          last_error_next = i2cms_pkg::ERR_BUS;
          a_action        = i2cms_pkg::ACT_STOP;
        end
        default: begin
        end
      endcase
      if (a_action == i2cms_pkg::ACT_STOP || a_action == i2cms_pkg::ACT_ABORT) begin
        phase_next = PH_READY;
        a_done     = 1'b1;
      end
    end else begin
    end
  end

  // Transmit buffer: written by loads while idle, read by status events while busy.
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      buf_mem[load_pointer[AW-1:0]] <= data_byte;
    end
    if (accept) begin
      mem_q <= buf_mem[byte_index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_READY;
      load_pointer <= '0;
      address_byte <= '0;
      length_reg   <= '0;
      byte_index   <= '0;
      last_error   <= i2cms_pkg::ERR_NONE;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        load_pointer <= load_pointer_next;
        address_byte <= address_byte_next;
        length_reg   <= length_reg_next;
        byte_index   <= byte_index_next;
        last_error   <= last_error_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action  <= a_action;
      s1_txb     <= a_txb;
      s1_use_mem <= a_use_mem;
      s1_rxv     <= a_rxv;
      s1_rxb     <= a_rxv ? data_byte : 8'd0;
      s1_busy    <= phase_next != PH_READY;
      s1_done    <= a_done;
      s1_err     <= last_error_next;
      s1_count   <= byte_index_next;
    end
    if (s1_move) begin
      bus_action <= s1_action;
      tx_byte    <= s1_use_mem ? mem_q : s1_txb;
      rx_valid   <= s1_rxv;
      rx_byte    <= s1_rxb;
      busy_res   <= s1_busy;
      done_res   <= s1_done;
      error_code <= s1_err;
      byte_count <= s1_count;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_rx_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && rx_valid |-> (bus_action == i2cms_pkg::ACT_RX_ACK ||
                               bus_action == i2cms_pkg::ACT_RX_NACK ||
                               bus_action == i2cms_pkg::ACT_STOP))
    else $error("received byte without a receive-side action");

  a_len_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == i2cms_pkg::ERR_LEN |-> !busy_res)
    else $error("length error with a transaction in progress");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_action) &&
                             (!s1_use_mem || $stable(mem_q)))
    else $error("first stage overwritten while held");

endmodule
`default_nettype wire
